[hdl/cubic_arc_length_quadrature_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the arc length quadrature unit
// Shorthand for clocked implications with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef CUBIC_ARC_LENGTH_QUADRATURE_UNIT_MACROS_SVH
`define CUBIC_ARC_LENGTH_QUADRATURE_UNIT_MACROS_SVH

// Same-cycle implication.
`define CALQ_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("calq: same-cycle check failed");

// Next-cycle implication.
`define CALQ_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("calq: next-cycle check failed");

`endif

[hdl/calq_pkg.sv]
// ----------------------------------------------------------------------------
// calq_pkg
// Widths, node and weight tables and shared types of the quadrature unit.
// ----------------------------------------------------------------------------
package calq_pkg;

    localparam int U_W       = 17;
    localparam int COEF_W    = 32;
    localparam int LEN_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int E_W       = 18;
    localparam int N_W       = 50;
    localparam int V_W       = 56;
    localparam int RAD_W     = 54;
    localparam int ROOT_W    = 35;
    localparam int REM_W     = 39;
    localparam int SQ_ITERS  = 35;
    localparam int X_W       = 30;
    localparam int W_W       = 25;
    localparam int WP_W      = 60;
    localparam int ACC_W     = 63;
    localparam int A_W       = 37;
    localparam int M_W       = 55;
    localparam int NODE_CNT  = 10;
    localparam int CNT_W     = 4;

    localparam logic [U_W-1:0]        U_ONE       = U_W'(65536);
    localparam logic signed [N_W-1:0] N_RND       = N_W'(1 << 30);
    localparam logic [M_W-1:0]        LEN_POS_MAX = M_W'(48'h7FFF_FFFF_FFFF);
    localparam logic [M_W-1:0]        LEN_NEG_MAG = M_W'(48'h8000_0000_0000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_X = 3'd0,
        CFG_A_Y = 3'd1,
        CFG_B_X = 3'd2,
        CFG_B_Y = 3'd3,
        CFG_C_X = 3'd4,
        CFG_C_Y = 3'd5
    } t_cfg_reg;

    // Control that travels with every node through the evaluator.
    typedef struct packed {
        logic                  first;
        logic                  last;
        logic [2:0]            widx;
        logic signed [E_W-1:0] e;
    } t_tag;

    // Positive Gauss-Legendre abscissas scaled by 2^30.
    function automatic logic [X_W-1:0] node_x(input logic [2:0] i);
        logic [X_W-1:0] x;
        unique case (i)
            3'd0:    x = X_W'(159852604);
            3'd1:    x = X_W'(465354761);
            3'd2:    x = X_W'(729510469);
            3'd3:    x = X_W'(928854717);
            3'd4:    x = X_W'(1045724172);
            default: x = '0;
        endcase
        return x;
    endfunction

    // Matching weights scaled by 2^26.
    function automatic logic [W_W-1:0] node_w(input logic [2:0] i);
        logic [W_W-1:0] w;
        unique case (i)
            3'd0:    w = W_W'(19832295);
            3'd1:    w = W_W'(18070184);
            3'd2:    w = W_W'(14702637);
            3'd3:    w = W_W'(10029510);
            3'd4:    w = W_W'(4474238);
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

[hdl/calq_if.sv]
// ----------------------------------------------------------------------------
// calq_req_if / calq_rsp_if
// Valid/ready channels carrying an interval request and its arc length.
// ----------------------------------------------------------------------------
interface calq_req_if;
    import calq_pkg::*;
    logic           valid;
    logic           ready;
    logic [U_W-1:0] u_start;
    logic [U_W-1:0] u_end;
    modport source (output valid, output u_start, output u_end, input ready);
    modport sink   (input valid, input u_start, input u_end, output ready);
endinterface

interface calq_rsp_if;
    import calq_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [LEN_W-1:0] arc_length;
    logic                    saturated;
    modport source (output valid, output arc_length, output saturated, input ready);
    modport sink   (input valid, input arc_length, input saturated, output ready);
endinterface

[hdl/cubic_arc_length_quadrature_unit.sv]
// ----------------------------------------------------------------------------
// cubic_arc_length_quadrature_unit
// Ten-point Gauss-Legendre arc length of a 2D cubic over [u_start, u_end].
// ----------------------------------------------------------------------------
// Usage. Six Q16.16 curve coefficients are written through the plain write
// port (i_cfg_we, i_cfg_idx, i_cfg_data); writes to indexes above five are
// dropped. After a write the request channel holds ready low while the
// speed-squared polynomial is rebuilt from the new coefficients.
// Each request on i_req carries an interval in Q1.16; values above one are
// clamped to one. Each request yields exactly one response on o_rsp with a
// signed Q31.16 length and a saturation flag, in request order.
// The ten quadrature nodes of a request enter the Horner and square-root
// pipeline one per cycle while o_rsp does not stall, and the next request
// issues right behind the last node of the previous one.
// A one-entry request register lets the next request be taken while the
// previous one is still issuing or its response waits. When o_rsp stalls the
// whole pipeline freezes in place; nothing is dropped or repeated.
// Reset is synchronous: it empties every stage and clears the coefficients.
// ----------------------------------------------------------------------------
module cubic_arc_length_quadrature_unit #(
    parameter int SQ_PER_STAGE = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    calq_req_if.sink                        i_req,
    calq_rsp_if.source                      o_rsp,
    input  logic                            i_cfg_we,
    input  logic [calq_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [calq_pkg::COEF_W-1:0]     i_cfg_data
);
    import calq_pkg::*;

    localparam int SQ_ST  = (SQ_ITERS + SQ_PER_STAGE - 1) / SQ_PER_STAGE;
    localparam int NT     = 6 + SQ_ST;
    localparam int T_WGT  = 5 + SQ_ST;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NODE_CNT - 1);

    // Coefficients and derived polynomial.
    logic signed [COEF_W-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [63:0] r_m_axax, r_m_ayay, r_m_axbx, r_m_ayby, r_m_axcx, r_m_aycy;
    logic signed [63:0] r_m_bxbx, r_m_byby, r_m_bxcx, r_m_bycy, r_m_cxcx, r_m_cycy;
    logic signed [V_W-1:0] r_p [0:4];
    logic [1:0] r_cfg_hold;

    // Request register and node issue.
    logic           r_in_vld;
    logic [U_W-1:0] r_us, r_ue;
    logic           r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [U_W:0]   r_s;
    logic signed [E_W-1:0] r_e;
    logic           iss_load, adv, in_acc;

    // Node pipeline.
    logic             r_vld [0:NT-1];
    t_tag             r_tag [0:NT-1];
    t_tag             node_tag;
    logic [U_W-1:0]   r_nu;
    logic [U_W-1:0]   nu;
    logic signed [V_W-1:0] r_hv [0:3];
    logic [U_W-1:0]   r_hu [0:3];
    logic [RAD_W-1:0] sq_rad_in [0:SQ_ST-1];
    logic [ROOT_W-1:0] sq_root_in [0:SQ_ST-1];
    logic [REM_W-1:0] sq_rem_in [0:SQ_ST-1];
    logic [RAD_W-1:0] r_sq_rad [0:SQ_ST-1];
    logic [ROOT_W-1:0] r_sq_root [0:SQ_ST-1];
    logic [REM_W-1:0] r_sq_rem [0:SQ_ST-1];
    logic [WP_W-1:0]  r_wp;

    // Item tail: accumulate, round, scale, saturate.
    logic [ACC_W-1:0] r_acc, acc_n;
    logic             r_sv, r_av, r_mv;
    logic [ACC_W-1:0] r_sum;
    logic signed [E_W-1:0] r_se;
    logic [A_W-1:0]   r_a;
    logic [U_W-1:0]   r_ae;
    logic             r_aneg, r_mneg;
    logic [M_W-1:0]   r_mraw, mag;
    logic             sat;
    logic [LEN_W-1:0] len;
    logic             r_out_vld;
    logic [LEN_W-1:0] r_len;
    logic             r_sat;

    function automatic logic signed [V_W-1:0] tq(input logic signed [63:0] m);
        return V_W'(m >>> 16);
    endfunction

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax <= '0; r_ay <= '0; r_bx <= '0;
            r_by <= '0; r_cx <= '0; r_cy <= '0;
            r_cfg_hold <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_hold <= 2'd3;
                unique case (t_cfg_reg'(i_cfg_idx))
                    CFG_A_X: r_ax <= i_cfg_data;
                    CFG_A_Y: r_ay <= i_cfg_data;
                    CFG_B_X: r_bx <= i_cfg_data;
                    CFG_B_Y: r_by <= i_cfg_data;
                    CFG_C_X: r_cx <= i_cfg_data;
                    CFG_C_Y: r_cy <= i_cfg_data;
                    default: ;
                endcase
            end else if (r_cfg_hold != 2'd0) begin
                r_cfg_hold <= r_cfg_hold - 2'd1;
            end
        end
    end

    // The speed squared is (3a u^2 + 2b u + c)^2 summed over x and y.
    always_ff @(posedge i_clk) begin
        r_m_axax <= r_ax * r_ax;  r_m_ayay <= r_ay * r_ay;
        r_m_axbx <= r_ax * r_bx;  r_m_ayby <= r_ay * r_by;
        r_m_axcx <= r_ax * r_cx;  r_m_aycy <= r_ay * r_cy;
        r_m_bxbx <= r_bx * r_bx;  r_m_byby <= r_by * r_by;
        r_m_bxcx <= r_bx * r_cx;  r_m_bycy <= r_by * r_cy;
        r_m_cxcx <= r_cx * r_cx;  r_m_cycy <= r_cy * r_cy;
    end

    always_ff @(posedge i_clk) begin
        logic signed [V_W-1:0] s4, s3, s2a, s2b, s1, s0;
        s4  = tq(r_m_axax) + tq(r_m_ayay);
        s3  = tq(r_m_axbx) + tq(r_m_ayby);
        s2a = tq(r_m_axcx) + tq(r_m_aycy);
        s2b = tq(r_m_bxbx) + tq(r_m_byby);
        s1  = tq(r_m_bxcx) + tq(r_m_bycy);
        s0  = tq(r_m_cxcx) + tq(r_m_cycy);
        r_p[4] <= (s4 <<< 3) + s4;
        r_p[3] <= (s3 <<< 3) + (s3 <<< 2);
        r_p[2] <= (s2a <<< 2) + (s2a <<< 1) + (s2b <<< 2);
        r_p[1] <= s1 <<< 2;
        r_p[0] <= s0;
    end

    // ---------------------------------------------------------------- issue
    assign adv         = !r_out_vld || o_rsp.ready;
    assign i_req.ready = !r_in_vld && (r_cfg_hold == 2'd0);
    assign in_acc      = i_req.valid && i_req.ready;
    assign iss_load    = r_in_vld && (!r_busy || (adv && r_cnt == CNT_LAST));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_busy   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (in_acc) begin
                r_in_vld <= 1'b1;
            end else if (iss_load) begin
                r_in_vld <= 1'b0;
            end
            if (iss_load) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (adv && r_busy) begin
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_us <= (i_req.u_start > U_ONE) ? U_ONE : i_req.u_start;
            r_ue <= (i_req.u_end   > U_ONE) ? U_ONE : i_req.u_end;
        end
        if (iss_load) begin
            r_s <= {1'b0, r_us} + {1'b0, r_ue};
            r_e <= $signed({1'b0, r_ue}) - $signed({1'b0, r_us});
        end
    end

    // Node position: round((s + e*x) / 2) in Q1.16, odd counts take -x.
    always_comb begin
        logic signed [N_W-1:0] e_x, x_x, off, num;
        e_x = N_W'(r_e);
        x_x = N_W'($signed({1'b0, node_x(r_cnt[3:1])}));
        off = e_x * x_x;
        num = (N_W'($signed({1'b0, r_s})) <<< 30) + (r_cnt[0] ? -off : off) + N_RND;
        nu  = (num < 0) ? '0 : num[31 +: U_W];
        node_tag.first = (r_cnt == '0);
        node_tag.last  = (r_cnt == CNT_LAST);
        node_tag.widx  = r_cnt[3:1];
        node_tag.e     = r_e;
    end

    // ---------------------------------------------------------------- pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NT; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= r_busy;
            for (int i = 1; i < NT; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tag[0] <= node_tag;
            for (int i = 1; i < NT; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
            r_nu <= nu;
        end
    end

    // Horner steps, one per stage: v = p[k] + floor(v*u / 2^16).
    for (genvar h = 0; h < 4; h++) begin : g_horner
        logic signed [V_W-1:0] v_in;
        logic [U_W-1:0]        u_in;
        logic signed [V_W+U_W:0] prod;
        if (h == 0) begin : g_first
            assign v_in = r_p[4];
            assign u_in = r_nu;
        end else begin : g_rest
            assign v_in = r_hv[h-1];
            assign u_in = r_hu[h-1];
        end
        assign prod = (V_W+U_W+1)'(v_in) * (V_W+U_W+1)'($signed({1'b0, u_in}));
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_hv[h] <= r_p[3-h] + V_W'(prod >>> 16);
                r_hu[h] <= u_in;
            end
        end
    end

    // Restoring square root of max(v,0) * 2^16, SQ_PER_STAGE bits per stage.
    for (genvar g = 0; g < SQ_ST; g++) begin : g_sqrt
        if (g == 0) begin : g_first
            assign sq_rad_in[g]  = (r_hv[3] < 0) ? '0 : r_hv[3][RAD_W-1:0];
            assign sq_root_in[g] = '0;
            assign sq_rem_in[g]  = '0;
        end else begin : g_rest
            assign sq_rad_in[g]  = r_sq_rad[g-1];
            assign sq_root_in[g] = r_sq_root[g-1];
            assign sq_rem_in[g]  = r_sq_rem[g-1];
        end
        always_ff @(posedge i_clk) begin
            logic [ROOT_W-1:0] root;
            logic [REM_W-1:0]  rem, trial;
            logic [1:0]        pair;
            int                k;
            root = sq_root_in[g];
            rem  = sq_rem_in[g];
            for (int t = 0; t < SQ_PER_STAGE; t++) begin
                if (g * SQ_PER_STAGE + t < SQ_ITERS) begin
                    k = SQ_ITERS - 1 - (g * SQ_PER_STAGE + t);
                    if (k >= 8) begin
                        pair = sq_rad_in[g][2*(k-8) +: 2];
                    end else begin
                        pair = 2'b00;
                    end
                    rem   = {rem[REM_W-3:0], pair};
                    trial = REM_W'({root, 2'b01});
                    if (rem >= trial) begin
                        rem  = rem - trial;
                        root = {root[ROOT_W-2:0], 1'b1};
                    end else begin
                        root = {root[ROOT_W-2:0], 1'b0};
                    end
                end
            end
            if (adv) begin
                r_sq_rad[g]  <= sq_rad_in[g];
                r_sq_root[g] <= root;
                r_sq_rem[g]  <= rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wp <= WP_W'(node_w(r_tag[T_WGT-1].widx)) * WP_W'(r_sq_root[SQ_ST-1]);
        end
    end

    // ---------------------------------------------------------------- tail
    assign acc_n = (r_tag[T_WGT].first ? '0 : r_acc) + ACC_W'(r_wp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv      <= 1'b0;
            r_av      <= 1'b0;
            r_mv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_sv      <= r_vld[T_WGT] && r_tag[T_WGT].last;
            r_av      <= r_sv;
            r_mv      <= r_av;
            r_out_vld <= r_mv;
        end
    end

    always_comb begin
        logic [M_W-1:0] rounded;
        rounded = r_mraw + M_W'(1 << 16);
        mag     = rounded >> 17;
        if (r_mneg) begin
            sat = (mag > LEN_NEG_MAG);
            len = sat ? LEN_NEG_MAG[LEN_W-1:0] : (~mag[LEN_W-1:0] + LEN_W'(1));
        end else begin
            sat = (mag > LEN_POS_MAX);
            len = sat ? LEN_POS_MAX[LEN_W-1:0] : mag[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_vld[T_WGT]) begin
                r_acc <= acc_n;
            end
            r_sum  <= acc_n;
            r_se   <= r_tag[T_WGT].e;
            r_a    <= A_W'((r_sum + ACC_W'(1 << 25)) >> 26);
            r_ae   <= (r_se < 0) ? U_W'(-r_se) : U_W'(r_se);
            r_aneg <= (r_se < 0);
            r_mraw <= M_W'(r_a) * M_W'(r_ae);
            r_mneg <= r_aneg;
            r_len  <= len;
            r_sat  <= sat;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.arc_length = r_len;
    assign o_rsp.saturated  = r_sat;

endmodule

[hdl/calq_checker.sv]
// ----------------------------------------------------------------------------
// calq_checker
// Port-level checks of the quadrature unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "cubic_arc_length_quadrature_unit_macros.svh"

module calq_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_out_sat,
    input logic [calq_pkg::LEN_W-1:0]     i_out_len,
    input logic                           i_cfg_we
);
    // A stalled response keeps its value.
    `CALQ_NEXT(a_rsp_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_len))
    // The request register is one deep, so a taken request closes the channel.
    `CALQ_NEXT(a_req_one_deep, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // A coefficient write blocks requests while the polynomial is rebuilt.
    `CALQ_NEXT(a_cfg_blocks, i_clk, i_rst_n, i_cfg_we, !i_in_ready)
    // Clamped intervals can never reach the length limits.
    `CALQ_IMPLY(a_no_sat, i_clk, i_rst_n, i_out_valid, !i_out_sat)
endmodule

bind cubic_arc_length_quadrature_unit calq_checker u_calq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_sat   (o_rsp.saturated),
    .i_out_len   (o_rsp.arc_length),
    .i_cfg_we    (i_cfg_we)
);

[bench/tb_cubic_arc_length_quadrature_unit.sv]
// ----------------------------------------------------------------------------
// tb_cubic_arc_length_quadrature_unit
// Self-checking bench for the ten-point quadrature arc length unit.
// A short table of interval requests comes first. The table is run at reset
// coefficients and again after a simple curve has been loaded. Random
// requests follow under a series of coefficient sets, the extremes among
// them. Each response is checked against a length typed in the table or
// a bit-exact in-bench fixed-point predictor. Both channels stall at random,
// and once the response side holds off long enough that the unit backs up.
// ----------------------------------------------------------------------------
module tb_cubic_arc_length_quadrature_unit;
    import calq_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int LONG_HOLD      = 400;
    localparam int RAND_SETS      = 8;
    localparam int ITEMS_PER_SET  = 170;

    // These indexes name no register; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam longint HALF_Q31 = 64'sd1 << 30;

    // Gauss-Legendre abscissas (scaled by 2^30) and weights (scaled by 2^26).
    localparam longint ABSC[5] = '{159852604, 465354761, 729510469, 928854717, 1045724172};
    localparam longint WGHT[5] = '{19832295, 18070184, 14702637, 10029510, 4474238};

    typedef struct {
        logic signed [LEN_W-1:0] len;
        logic                    sat;
    } t_length;

    // One row of the directed table. When known is set the expected length is
    // the one typed in the row; otherwise the predictor supplies it.
    typedef struct {
        logic [U_W-1:0]          u_start;
        logic [U_W-1:0]          u_end;
        bit                      known;
        logic signed [LEN_W-1:0] len;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COEF_W-1:0]    i_cfg_data;

    calq_req_if req_ch ();
    calq_rsp_if rsp_ch ();

    cubic_arc_length_quadrature_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the six curve coefficients, sign-extended.
    longint  curve_coef[6];
    t_length pending_lengths[$];
    int      error_count;
    int      quiet_cycles;
    bit      steady_flow;       // when set neither side idles
    bit      long_hold_request; // asks the response side for one long stall
    int      hold_left;

    t_row directed_rows[12] = '{
        '{17'd0,      17'd0,      1'b1, 48'sd0},
        '{17'd65536,  17'd65536,  1'b1, 48'sd0},
        '{17'd131071, 17'd131071, 1'b1, 48'sd0},
        '{17'd0,      17'd65536,  1'b0, 48'sd0},
        '{17'd65536,  17'd0,      1'b0, 48'sd0},
        '{17'd131071, 17'd0,      1'b0, 48'sd0},
        '{17'd0,      17'd131071, 1'b0, 48'sd0},
        '{17'd1,      17'd0,      1'b0, 48'sd0},
        '{17'd0,      17'd1,      1'b0, 48'sd0},
        '{17'd32768,  17'd32769,  1'b0, 48'sd0},
        '{17'd12345,  17'd54321,  1'b0, 48'sd0},
        '{17'd65535,  17'd65536,  1'b0, 48'sd0}
    };

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Product of two Q16.16 values, floored back to Q.16.
    function automatic longint q16_product(input longint p, input longint q);
        return (p * q) >>> 16;
    endfunction

    // floor(v * u / 2^16) with a wide intermediate so nothing overflows.
    function automatic longint scale_by_param(input longint v, input longint u);
        logic signed [127:0] wide;
        wide = 128'(v) * 128'(u);
        return longint'(wide >>> 16);
    endfunction

    // Bit-serial floor(sqrt(s * 2^16)); only the low 54 bits of s take part.
    function automatic logic [63:0] speed_root(input logic [63:0] s);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] trial;
        logic [1:0]  pair;
        root = '0;
        rem  = '0;
        for (int k = 34; k >= 0; k--) begin
            pair  = (k >= 8) ? s[2*(k-8) +: 2] : 2'b00;
            rem   = (rem << 2) | 64'(pair);
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 64'd1;
            end else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic t_length predict_length(input logic [U_W-1:0] u_start,
                                               input logic [U_W-1:0] u_end);
        longint      poly[5];
        longint      u1, u2, s, e, ae, off, num, u, v;
        logic [63:0] acc, a, mag, fp;
        t_length     res;
        u1 = (u_start > U_ONE) ? longint'(U_ONE) : longint'(u_start);
        u2 = (u_end > U_ONE) ? longint'(U_ONE) : longint'(u_end);

        // Speed squared of the derivative, as a quartic in u.
        poly[4] = 9 * (q16_product(curve_coef[CFG_A_X], curve_coef[CFG_A_X])
                     + q16_product(curve_coef[CFG_A_Y], curve_coef[CFG_A_Y]));
        poly[3] = 12 * (q16_product(curve_coef[CFG_A_X], curve_coef[CFG_B_X])
                      + q16_product(curve_coef[CFG_A_Y], curve_coef[CFG_B_Y]));
        poly[2] = 6 * (q16_product(curve_coef[CFG_A_X], curve_coef[CFG_C_X])
                     + q16_product(curve_coef[CFG_A_Y], curve_coef[CFG_C_Y]))
                + 4 * (q16_product(curve_coef[CFG_B_X], curve_coef[CFG_B_X])
                     + q16_product(curve_coef[CFG_B_Y], curve_coef[CFG_B_Y]));
        poly[1] = 4 * (q16_product(curve_coef[CFG_B_X], curve_coef[CFG_C_X])
                     + q16_product(curve_coef[CFG_B_Y], curve_coef[CFG_C_Y]));
        poly[0] = q16_product(curve_coef[CFG_C_X], curve_coef[CFG_C_X])
                + q16_product(curve_coef[CFG_C_Y], curve_coef[CFG_C_Y]);

        s   = u1 + u2;
        e   = u2 - u1;
        acc = '0;
        for (int i = 0; i < 5; i++) begin
            for (int side = 0; side < 2; side++) begin
                off = e * ABSC[i];
                num = s * HALF_Q31 + ((side != 0) ? -off : off) + HALF_Q31;
                if (num < 0) begin
                    num = 0;
                end
                u = num >>> 31;
                v = poly[4];
                for (int k = 3; k >= 0; k--) begin
                    v = poly[k] + scale_by_param(v, u);
                end
                // Rounding can push the speed squared below zero.
                if (v < 0) begin
                    v = 0;
                end
                fp  = speed_root(64'(v));
                acc = acc + 64'(WGHT[i]) * fp;
            end
        end
        a   = (acc + (64'd1 << 25)) >> 26;
        ae  = (e < 0) ? -e : e;
        mag = (a * 64'(ae) + (64'd1 << 16)) >> 17;

        // Clip to the 48-bit range; the negative side reaches one further.
        res.sat = 1'b0;
        if (e < 0) begin
            if (mag > 64'h0000_8000_0000_0000) begin
                res.len = {1'b1, {(LEN_W-1){1'b0}}};
                res.sat = 1'b1;
            end else begin
                res.len = LEN_W'(-mag);
            end
        end else begin
            if (mag > 64'h0000_7FFF_FFFF_FFFF) begin
                res.len = {1'b0, {(LEN_W-1){1'b1}}};
                res.sat = 1'b1;
            end else begin
                res.len = LEN_W'(mag);
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and watchdog
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Counts cycles without any accepted request, response or register
    // write; a hang ends the run.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Response side: checks each response against the oldest expectation
    // and decides ready for the next cycle.
    // ------------------------------------------------------------------
    initial begin
        t_length want;
        int      r;
        rsp_ch.ready = 1'b0;
        hold_left    = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
                if (pending_lengths.size() == 0) begin
                    $display("%0t: response with nothing expected, got len=%0d sat=%0b",
                             $time, rsp_ch.arc_length, rsp_ch.saturated);
                    error_count++;
                end else begin
                    want = pending_lengths.pop_front();
                    if (rsp_ch.arc_length !== want.len) begin
                        $display("%0t: arc_length expected %0d, got %0d",
                                 $time, want.len, rsp_ch.arc_length);
                        error_count++;
                    end
                    if (rsp_ch.saturated !== want.sat) begin
                        $display("%0t: saturated expected %0b, got %0b",
                                 $time, want.sat, rsp_ch.saturated);
                        error_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (long_hold_request) begin
                // One long stall so that the pipeline and the request
                // register fill and the request side backs up.
                long_hold_request = 1'b0;
                hold_left = LONG_HOLD;
                rsp_ch.ready <= 1'b0;
            end else if (steady_flow || !i_rst_n) begin
                rsp_ch.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    hold_left = $urandom_range(10, 60);
                    rsp_ch.ready <= 1'b0;
                end else begin
                    rsp_ch.ready <= (r < 70);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side and configuration
    // ------------------------------------------------------------------

    // Offers one interval, after a random gap, and records the expected
    // length once the request is taken.
    task automatic send_interval(input logic [U_W-1:0] u_start,
                                 input logic [U_W-1:0] u_end,
                                 input bit known,
                                 input logic signed [LEN_W-1:0] known_len);
        int      gap;
        int      r;
        t_length want;
        gap = 0;
        if (!steady_flow) begin
            r = $urandom_range(0, 99);
            if (r >= 95) begin
                gap = $urandom_range(15, 60);
            end else if (r >= 60) begin
                gap = $urandom_range(1, 4);
            end
        end
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.u_start <= u_start;
        req_ch.u_end   <= u_end;
        do @(posedge i_clk); while (!req_ch.ready);
        want = predict_length(u_start, u_end);
        if (known) begin
            want.len = known_len;
            want.sat = 1'b0;
        end
        pending_lengths.push_back(want);
    endtask

    // Lets every outstanding response arrive, then the pipeline settle.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_lengths.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the shadow copy follows the rule that spare
    // indexes are dropped.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < 6) begin
            curve_coef[idx] = longint'(signed'(data));
        end
    endtask

    task automatic load_curve(input logic [COEF_W-1:0] ax, input logic [COEF_W-1:0] ay,
                              input logic [COEF_W-1:0] bx, input logic [COEF_W-1:0] by,
                              input logic [COEF_W-1:0] cx, input logic [COEF_W-1:0] cy);
        write_reg(CFG_A_X, ax);
        write_reg(CFG_A_Y, ay);
        write_reg(CFG_B_X, bx);
        write_reg(CFG_B_Y, by);
        write_reg(CFG_C_X, cx);
        write_reg(CFG_C_Y, cy);
    endtask

    // Coefficients mostly of moderate size, now and then any 32-bit value.
    function automatic logic [COEF_W-1:0] pick_coef();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom;
        end
        return COEF_W'($urandom_range(0, 2 * (1 << 21)) - (1 << 21));
    endfunction

    // Parameters mostly in [0, 1]; some above one to exercise the clamp and
    // every bit of the field.
    function automatic logic [U_W-1:0] pick_param();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return U_W'($urandom_range(65537, 131071));
        end else if (r < 14) begin
            return (r < 11) ? U_W'(0) : U_ONE;
        end
        return U_W'($urandom_range(0, 65536));
    endfunction

    task automatic run_table();
        foreach (directed_rows[i]) begin
            send_interval(directed_rows[i].u_start, directed_rows[i].u_end,
                          directed_rows[i].known, directed_rows[i].len);
        end
        wait_idle();
    endtask

    task automatic run_random(input int count);
        logic [U_W-1:0] a;
        for (int i = 0; i < count; i++) begin
            a = pick_param();
            // Empty intervals now and then.
            send_interval(a, ($urandom_range(0, 19) == 0) ? a : pick_param(), 1'b0, '0);
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = '0;
        i_cfg_data        = '0;
        req_ch.valid      = 1'b0;
        req_ch.u_start    = '0;
        req_ch.u_end      = '0;
        error_count       = 0;
        quiet_cycles      = 0;
        steady_flow       = 1'b0;
        long_hold_request = 1'b0;
        foreach (curve_coef[i]) begin
            curve_coef[i] = 0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at reset coefficients: every length is zero.
        run_table();

        // A straight line along x at unit speed, plus stray writes to the
        // spare indexes that must change nothing.
        load_curve('0, '0, '0, '0, 32'h0001_0000, '0);
        write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_HI, 32'h5A5A_A5A5);
        run_table();

        // Extremes of the coefficients.
        load_curve(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        run_random(60);
        load_curve(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        run_random(60);
        // A curve whose speed squared dips near zero, where rounding can
        // make it negative.
        load_curve(32'h0001_0000, '0, 32'hFFFE_8000, '0, 32'h0000_C000, '0);
        run_random(60);

        for (int set = 0; set < RAND_SETS; set++) begin
            load_curve(pick_coef(), pick_coef(), pick_coef(),
                       pick_coef(), pick_coef(), pick_coef());
            if (set == 1) begin
                long_hold_request = 1'b1;
            end
            steady_flow = (set == 3);
            run_random(ITEMS_PER_SET);
        end
        steady_flow = 1'b0;
        load_curve('0, '0, '0, '0, '0, '0);
        run_random(20);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/calq_pkg.sv
hdl/calq_if.sv
hdl/cubic_arc_length_quadrature_unit.sv
hdl/calq_checker.sv
bench/tb_cubic_arc_length_quadrature_unit.sv
